>>> hdl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
// No dependencies; imported by the row unit, top level, checker and testbench.
package pba_pkg;

  // bitmap row geometry: one memory row holds 64 page bits
  localparam int ROW_BITS  = 64;
  localparam int ROW_SHIFT = 6;

  // used-memory counter
  localparam int               COUNT_W     = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 19'h7FFFF;
  localparam logic [COUNT_W-1:0] KB_PER_PAGE = 19'd4;
  localparam int               KB_SHIFT    = 2;

  // reserved page register
  localparam int RSV_W          = 17;
  localparam int RESET_RESERVED = 4096;

  // operation codes on in_func
  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_INIT  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ALLOC_RD,
    ST_ALLOC_CHK,
    ST_FREE_RD,
    ST_FREE_WR
  } state_t;

  // row unit operations
  typedef enum logic [1:0] {
    ROP_FILL,
    ROP_FIND_SET,
    ROP_CLEAR
  } rop_t;

  // control from the sequencer to the row unit
  typedef struct packed {
    rop_t                 op;
    logic [ROW_SHIFT-1:0] bit_sel;
  } row_ctl_t;

endpackage

>>> hdl/pba_bitmap_ram.sv
// Occupancy bitmap storage: one write port, one registered read port.
// Depends on nothing; instanced by page_bitmap_allocator_unit.
module pba_bitmap_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pba_row_unit.sv
// Shared row unit: builds init fill rows, finds and sets the lowest free
// page bit, and clears a page bit. Depends on pba_pkg.
module pba_row_unit #(
  parameter int BITMAP_BYTES = 8192,
  localparam int TOTAL_PAGES = BITMAP_BYTES * 8,
  localparam int ROWS        = (TOTAL_PAGES + pba_pkg::ROW_BITS - 1) / pba_pkg::ROW_BITS,
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int NPW         = $clog2(TOTAL_PAGES + 1)
) (
  input  pba_pkg::row_ctl_t                  ctl,
  input  logic [ROW_AW-1:0]                  row_addr,
  input  logic [NPW-1:0]                     fill_n,
  input  logic [pba_pkg::ROW_BITS-1:0]       row_in,
  output logic [pba_pkg::ROW_BITS-1:0]       row_out,
  output logic                               found,
  output logic [pba_pkg::ROW_SHIFT-1:0]      pos
);
  import pba_pkg::*;

  localparam int CW         = ROW_AW + 8;
  localparam int LAST_VALID = TOTAL_PAGES - (ROWS - 1) * ROW_BITS;
  // bits of the last row that lie beyond the bitmap stay marked in use
  localparam logic [ROW_BITS-1:0] PAD_MASK =
    ~((ROW_BITS'(1) << LAST_VALID) - ROW_BITS'(1));

  logic [CW-1:0]       n_ext;
  logic [CW-1:0]       base_ext;
  logic [CW-1:0]       diff;
  logic [ROW_BITS-1:0] fill_row;

  assign n_ext    = CW'(fill_n);
  assign base_ext = CW'({row_addr, {ROW_SHIFT{1'b0}}});
  assign diff     = n_ext - base_ext;

  // init pattern: pages below fill_n set, padding set
  always_comb begin
    if (n_ext <= base_ext) begin
      fill_row = '0;
    end else if (diff >= CW'(ROW_BITS)) begin
      fill_row = '1;
    end else begin
      fill_row = (ROW_BITS'(1) << diff[ROW_SHIFT-1:0]) - ROW_BITS'(1);
    end
    if (row_addr == ROW_AW'(ROWS - 1)) begin
      fill_row = fill_row | PAD_MASK;
    end
  end

  // lowest clear bit of the row
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!row_in[i]) begin
        found = 1'b1;
        pos   = ROW_SHIFT'(i);
      end
    end
  end

  // row update
  always_comb begin
    unique case (ctl.op)
      ROP_FILL:     row_out = fill_row;
      ROP_FIND_SET: row_out = row_in | (ROW_BITS'(1) << pos);
      ROP_CLEAR:    row_out = row_in & ~(ROW_BITS'(1) << ctl.bit_sel);
      default:      row_out = row_in;
    endcase
  end

endmodule

>>> hdl/page_bitmap_allocator_unit.sv
// Top level of the page bitmap allocator: sequencer, counters and hookup of
// the bitmap memory and row unit. Depends on pba_pkg, pba_bitmap_ram, pba_row_unit.
//
// An item is taken when start is high and busy is low; its single result is
// shown for one cycle with out_valid and cannot be held off. The bitmap sits
// in a memory of 64-bit rows (BITMAP_BYTES/8 rows) with one read and one write
// port, and one row unit does all bit work. Allocate scans rows upward from a
// hint row (every row below it is full), reading each row in ST_ALLOC_RD and
// checking it in ST_ALLOC_CHK. Free reads the row in ST_FREE_RD and clears
// the bit in ST_FREE_WR. Init writes every row once, one row per cycle, and
// answers once the last row is written (1024 rows at the default size). Code 3
// and a free beyond the bitmap answer in the cycle after acceptance. After reset
// the same fill sweep runs over every row with busy high and gives no result.
// Configuration is always ready and is picked up by the next init.
module page_bitmap_allocator_unit #(
  parameter int BITMAP_BYTES = 8192
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_func,
  input  logic [15:0]                 in_page_index,
  output logic                        out_valid,
  output logic [15:0]                 out_page_number,
  output logic                        out_out_of_memory,
  output logic [pba_pkg::COUNT_W-1:0] out_used_kb,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pba_pkg::RSV_W-1:0]   cfg_data
);
  import pba_pkg::*;

  localparam int TOTAL_PAGES = BITMAP_BYTES * 8;
  localparam int ROWS        = (TOTAL_PAGES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int NPW         = $clog2(TOTAL_PAGES + 1);
  localparam int RST_N_I     = (RESET_RESERVED > TOTAL_PAGES) ? TOTAL_PAGES : RESET_RESERVED;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  state_t               state_r, state_nxt;
  logic [ROW_AW-1:0]    scan_r, scan_nxt;
  logic [ROW_AW-1:0]    hint_r, hint_nxt;
  logic [ROW_SHIFT-1:0] bit_r, bit_nxt;
  logic [NPW-1:0]       n_r, n_nxt;
  logic [COUNT_W-1:0]   used_kb_r, used_kb_nxt;
  logic [RSV_W-1:0]     reserved_r, reserved_nxt;
  logic                 emit_r, emit_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          out_page_r, out_page_nxt;
  logic                 out_oom_r, out_oom_nxt;

  row_ctl_t                        ctl;
  logic                            ram_we;
  logic [ROW_BITS-1:0]             ram_rdata;
  logic [ROW_BITS-1:0]             row_new;
  logic                            row_found;
  logic [ROW_SHIFT-1:0]            row_pos;
  logic [ROW_AW+ROW_SHIFT+15:0]    page_wide;
  logic [COUNT_W-1:0]              used_inc;
  logic [COUNT_W-1:0]              used_dec;
  logic [31:0]                     kb_w;
  logic [COUNT_W-1:0]              init_kb;
  logic [ROW_AW-1:0]               init_hint;
  logic [NPW-1:0]                  n_clamp;

  // bitmap storage
  pba_bitmap_ram #(
    .DEPTH (ROWS),
    .AW    (ROW_AW),
    .W     (ROW_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_r),
    .wdata (row_new),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  // shared row unit
  pba_row_unit #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_row (
    .ctl      (ctl),
    .row_addr (scan_r),
    .fill_n   (n_r),
    .row_in   (ram_rdata),
    .row_out  (row_new),
    .found    (row_found),
    .pos      (row_pos)
  );

  // counter arithmetic and init figures
  assign used_inc  = (used_kb_r > COUNT_MAX - KB_PER_PAGE) ? COUNT_MAX : used_kb_r + KB_PER_PAGE;
  assign used_dec  = (used_kb_r < KB_PER_PAGE) ? '0 : used_kb_r - KB_PER_PAGE;
  assign kb_w      = 32'(n_r) << KB_SHIFT;
  assign init_kb   = (kb_w > 32'(COUNT_MAX)) ? COUNT_MAX : kb_w[COUNT_W-1:0];
  assign init_hint = (32'(n_r >> ROW_SHIFT) >= 32'(ROWS - 1)) ? LAST_ROW
                                                              : ROW_AW'(n_r >> ROW_SHIFT);
  assign n_clamp   = (32'(reserved_r) > TOTAL_PAGES) ? NPW'(TOTAL_PAGES) : NPW'(reserved_r);
  assign page_wide = (ROW_AW + ROW_SHIFT + 16)'({scan_r, row_pos});

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    hint_nxt      = hint_r;
    bit_nxt       = bit_r;
    n_nxt         = n_r;
    used_kb_nxt   = used_kb_r;
    reserved_nxt  = reserved_r;
    emit_nxt      = emit_r;
    out_valid_nxt = 1'b0;
    out_page_nxt  = out_page_r;
    out_oom_nxt   = out_oom_r;
    ctl.op        = ROP_FILL;
    ctl.bit_sel   = bit_r;
    ram_we        = 1'b0;

    if (cfg_valid) begin
      reserved_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (func_t'(in_func))
            FN_ALLOC: begin
              scan_nxt  = hint_r;
              state_nxt = ST_ALLOC_RD;
            end
            FN_FREE: begin
              if (32'(in_page_index) < TOTAL_PAGES) begin
                scan_nxt  = ROW_AW'(in_page_index >> ROW_SHIFT);
                bit_nxt   = in_page_index[ROW_SHIFT-1:0];
                state_nxt = ST_FREE_RD;
              end else begin
                // page outside the bitmap: only the count moves
                used_kb_nxt   = used_dec;
                out_valid_nxt = 1'b1;
                out_page_nxt  = '0;
                out_oom_nxt   = 1'b0;
              end
            end
            FN_INIT: begin
              n_nxt     = n_clamp;
              scan_nxt  = '0;
              emit_nxt  = 1'b1;
              state_nxt = ST_INIT;
            end
            FN_NOP: begin
              out_valid_nxt = 1'b1;
              out_page_nxt  = '0;
              out_oom_nxt   = 1'b0;
            end
          endcase
        end
      end
      ST_INIT: begin
        ctl.op = ROP_FILL;
        ram_we = 1'b1;
        if (scan_r == LAST_ROW) begin
          hint_nxt      = init_hint;
          used_kb_nxt   = init_kb;
          out_valid_nxt = emit_r;
          out_page_nxt  = '0;
          out_oom_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      ST_ALLOC_RD: begin
        state_nxt = ST_ALLOC_CHK;
      end
      ST_ALLOC_CHK: begin
        ctl.op = ROP_FIND_SET;
        if (row_found) begin
          ram_we        = 1'b1;
          hint_nxt      = scan_r;
          used_kb_nxt   = used_inc;
          out_valid_nxt = 1'b1;
          out_page_nxt  = page_wide[15:0];
          out_oom_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (scan_r == LAST_ROW) begin
          // every row full
          hint_nxt      = scan_r;
          out_valid_nxt = 1'b1;
          out_page_nxt  = '0;
          out_oom_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = ST_ALLOC_RD;
        end
      end
      ST_FREE_RD: begin
        state_nxt = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        ctl.op        = ROP_CLEAR;
        ram_we        = 1'b1;
        hint_nxt      = (scan_r < hint_r) ? scan_r : hint_r;
        used_kb_nxt   = used_dec;
        out_valid_nxt = 1'b1;
        out_page_nxt  = '0;
        out_oom_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers; reset starts the fill sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      scan_r      <= '0;
      hint_r      <= '0;
      n_r         <= NPW'(RST_N_I);
      used_kb_r   <= '0;
      reserved_r  <= RSV_W'(RESET_RESERVED);
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      hint_r      <= hint_nxt;
      n_r         <= n_nxt;
      used_kb_r   <= used_kb_nxt;
      reserved_r  <= reserved_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    out_page_r <= out_page_nxt;
    out_oom_r  <= out_oom_nxt;
  end

  // ports
  assign busy              = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_page_number   = out_page_r;
  assign out_out_of_memory = out_oom_r;
  assign out_used_kb       = used_kb_r;

endmodule

>>> hdl/pba_checker.sv
// Port-level checks for page_bitmap_allocator_unit, bound to the top level.
// Depends on pba_pkg.
module pba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [1:0]                  in_func,
  input logic                        out_valid,
  input logic [15:0]                 out_page_number,
  input logic                        out_out_of_memory,
  input logic [pba_pkg::COUNT_W-1:0] out_used_kb
);
  import pba_pkg::*;

  // allocate and init always go through the sequencer
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_ALLOC || in_func == FN_INIT)) |=> busy)
    else $error("allocate or init accepted without going busy");

  // a result is only shown once the block is free again
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // out of memory returns page zero
  a_oom_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_memory) |-> (out_page_number == '0))
    else $error("out of memory with nonzero page");

  // out of memory leaves the count alone
  a_oom_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_memory) |-> $stable(out_used_kb))
    else $error("count changed on out of memory");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);

>>> test/testbench.sv
// Self-checking testbench for page_bitmap_allocator_unit: directed and random
// allocate, free, init and unused-code items against an in-order bitmap scoreboard.
// Depends on pba_pkg and the page_bitmap_allocator_unit RTL.
module testbench;
  import pba_pkg::*;

  localparam int BYTES = 8192;
  localparam int PAGES = BYTES * 8;
  localparam int ITEM_TARGET = 400;
  localparam int SETTLE_CYCLES = 2100;

  typedef struct {
    logic [15:0]        page;
    logic               oom;
    logic [COUNT_W-1:0] kb;
  } reply_t;

  // bitmap predictor and queue of replies still owed by the block
  class bitmap_scoreboard;
    logic [7:0]  page_bytes [BYTES];
    int unsigned used_kb;
    int unsigned reserved;
    int unsigned held_pages [$];
    reply_t      owed_replies [$];
    int          errors;

    function new();
      errors   = 0;
      reserved = RESET_RESERVED;
      apply_init();
    endfunction

    function void set_reserved(logic [RSV_W-1:0] value);
      reserved = 32'(value);
    endfunction

    // clear the map, then mark the reserved area at the bottom
    function void apply_init();
      int unsigned n;
      n = (reserved > PAGES) ? PAGES : reserved;
      for (int i = 0; i < BYTES; i++) begin
        page_bytes[i] = 8'h00;
      end
      for (int unsigned p = 0; p < n; p++) begin
        page_bytes[p >> 3][p & 7] = 1'b1;
      end
      used_kb = (n * 4 > COUNT_MAX) ? COUNT_MAX : n * 4;
      held_pages.delete();
    endfunction

    // apply one accepted item and queue its reply
    function void note_request(func_t f, logic [15:0] idx);
      reply_t      r;
      bit          found;
      int unsigned page;
      found  = 1'b0;
      page   = 0;
      r.page = '0;
      r.oom  = 1'b0;
      case (f)
        FN_ALLOC: begin
          // lowest clear bit of the first byte that is not full
          for (int i = 0; i < BYTES && !found; i++) begin
            if (page_bytes[i] != 8'hFF) begin
              for (int b = 0; b < 8 && !found; b++) begin
                if (!page_bytes[i][b]) begin
                  page_bytes[i][b] = 1'b1;
                  page  = i * 8 + b;
                  found = 1'b1;
                end
              end
            end
          end
          if (found) begin
            used_kb = (used_kb > COUNT_MAX - 4) ? COUNT_MAX : used_kb + 4;
            r.page  = page[15:0];
            held_pages.push_back(page);
          end else begin
            r.oom = 1'b1;
          end
        end
        FN_FREE: begin
          if ((idx >> 3) < BYTES) begin
            page_bytes[idx >> 3][idx[2:0]] = 1'b0;
          end
          used_kb = (used_kb < 4) ? 0 : used_kb - 4;
          for (int i = 0; i < held_pages.size(); i++) begin
            if (held_pages[i] == idx) begin
              held_pages.delete(i);
              break;
            end
          end
        end
        FN_INIT: apply_init();
        default: ;
      endcase
      r.kb = used_kb[COUNT_W-1:0];
      owed_replies.push_back(r);
    endfunction

    // compare one result with the oldest owed reply
    function void check_reply(logic [15:0] page, logic oom, logic [COUNT_W-1:0] kb);
      reply_t exp_r;
      if (owed_replies.size() == 0) begin
        $error("result with nothing expected: page_number %0d out_of_memory %0d used_kb %0d",
               page, oom, kb);
        errors++;
        return;
      end
      exp_r = owed_replies.pop_front();
      if (page !== exp_r.page) begin
        $error("page_number: expected %0d, actual %0d", exp_r.page, page);
        errors++;
      end
      if (oom !== exp_r.oom) begin
        $error("out_of_memory: expected %0d, actual %0d", exp_r.oom, oom);
        errors++;
      end
      if (kb !== exp_r.kb) begin
        $error("used_kb: expected %0d, actual %0d", exp_r.kb, kb);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_replies.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic [15:0]        in_page_index;
  logic               out_valid;
  logic [15:0]        out_page_number;
  logic               out_out_of_memory;
  logic [COUNT_W-1:0] out_used_kb;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [RSV_W-1:0]   cfg_data;

  bitmap_scoreboard sb;
  int               items_sent;

  page_bitmap_allocator_unit #(
    .BITMAP_BYTES(BYTES)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_page_index    (in_page_index),
    .out_valid        (out_valid),
    .out_page_number  (out_page_number),
    .out_out_of_memory(out_out_of_memory),
    .out_used_kb      (out_used_kb),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      sb.check_reply(out_page_number, out_out_of_memory, out_used_kb);
    end
  end

  // run limit
  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // send one item after an idle gap; entered and left on a rising edge
  task automatic send_item(func_t f, logic [15:0] idx, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= f;
    in_page_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(f, idx);
    items_sent++;
  endtask

  // hold off until every owed reply has come and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0 || busy !== 1'b0);
  endtask

  // write the reserved page count while idle
  task automatic write_reserved(logic [RSV_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_reserved(value);
    cfg_valid <= 1'b0;
  endtask

  // random item, mostly alloc and free of held pages
  task automatic pick_item(output func_t f, output logic [15:0] idx);
    int unsigned r;
    int          near;
    r   = $urandom_range(0, 99);
    idx = 16'($urandom_range(0, 16'hFFFF));
    if (r < 50) begin
      f = FN_ALLOC;
    end else if (r < 78 && sb.held_pages.size() > 0) begin
      f   = FN_FREE;
      idx = 16'(sb.held_pages[$urandom_range(0, sb.held_pages.size() - 1)]);
    end else if (r < 86) begin
      // free around the reserved boundary or anywhere
      f    = FN_FREE;
      near = int'(sb.reserved) + int'($urandom_range(0, 64)) - 32;
      if ($urandom_range(0, 1)) idx = near[15:0];
    end else if (r < 92) begin
      f = FN_INIT;
    end else begin
      f = FN_NOP;
    end
  endtask

  function automatic logic [RSV_W-1:0] pick_reserved();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return RSV_W'(8 * $urandom_range(0, PAGES / 8));
      2:       return RSV_W'($urandom_range(0, 17'h1FFFF));
      3:       return RSV_W'(PAGES - 8 * $urandom_range(0, 4));
      4:       return RSV_W'(PAGES - $urandom_range(1, 7));
      default: return RSV_W'(17'h1FFFF - $urandom_range(0, 65535));
    endcase
  endfunction

  // stimulus
  initial begin
    func_t       f;
    logic [15:0] idx;
    bit          burst;
    int          phase_len;

    sb            = new();
    items_sent    = 0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_func       <= FN_NOP;
    in_page_index <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // wait out the fill sweep after reset
    do @(posedge clk); while (busy !== 1'b0);

    // directed: reset layout, refree, unused code, reserved page
    send_item(FN_ALLOC, 16'h0000, $urandom_range(0, 19));
    send_item(FN_ALLOC, 16'hFFFF, $urandom_range(0, 19));
    send_item(FN_FREE, 16'd4096, $urandom_range(0, 19));
    send_item(FN_ALLOC, 16'h0000, 0);
    send_item(FN_FREE, 16'd4097, 0);
    send_item(FN_FREE, 16'd4097, $urandom_range(0, 19));
    send_item(FN_NOP, 16'hFFFF, $urandom_range(0, 19));
    send_item(FN_FREE, 16'd0, 0);
    send_item(FN_ALLOC, 16'h5555, 0);
    send_item(FN_FREE, 16'hFFFF, $urandom_range(0, 19));

    // directed: empty reserve, count underflow
    write_reserved('0);
    send_item(FN_INIT, 16'hAAAA, 0);
    send_item(FN_FREE, 16'd5, 0);
    send_item(FN_ALLOC, 16'h0000, $urandom_range(0, 19));
    send_item(FN_ALLOC, 16'h0000, 0);

    // directed: full map, out of memory, top page
    write_reserved(RSV_W'(PAGES));
    send_item(FN_INIT, 16'h0000, 0);
    send_item(FN_ALLOC, 16'h0000, 0);
    send_item(FN_FREE, 16'hFFFF, $urandom_range(0, 19));
    send_item(FN_ALLOC, 16'h0000, 0);
    send_item(FN_ALLOC, 16'h0000, 0);

    // directed: reserve beyond the map, then odd reserve
    write_reserved(17'h1FFFF);
    send_item(FN_INIT, 16'h0000, 0);
    send_item(FN_ALLOC, 16'h0000, $urandom_range(0, 19));
    write_reserved(17'd13);
    send_item(FN_INIT, 16'h0000, 0);
    send_item(FN_ALLOC, 16'h0000, 0);
    send_item(FN_NOP, 16'h0000, 0);

    // random phases, each with its own reserve setting
    while (items_sent < ITEM_TARGET) begin
      write_reserved(pick_reserved());
      burst     = ($urandom_range(0, 2) == 0);
      phase_len = $urandom_range(20, 60);
      send_item(FN_INIT, 16'($urandom_range(0, 16'hFFFF)), 0);
      for (int i = 0; i < phase_len; i++) begin
        pick_item(f, idx);
        if ($urandom_range(0, 24) == 0) drain();
        send_item(f, idx, burst ? 0 : $urandom_range(0, 19));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
